### hdl/lrsc_pkg.sv
package lrsc_pkg;

    // Command codes.
    localparam logic [2:0] CMD_FLUSH      = 3'd0;
    localparam logic [2:0] CMD_UNMAP      = 3'd1;
    localparam logic [2:0] CMD_UNREGISTER = 3'd2;
    localparam logic [2:0] CMD_ACCESS_TR  = 3'd3;
    localparam logic [2:0] CMD_ACCESS_KM  = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_FILLED  = 3'd2;
    localparam logic [2:0] ST_EVICTED = 3'd3;
    localparam logic [2:0] ST_REREG   = 3'd4;

    localparam logic [31:0] PBO_TARGET_A = 32'd35051;
    localparam logic [31:0] PBO_TARGET_B = 32'd35052;
    localparam logic [9:0]  CAP_RESET    = 10'd8;

    localparam logic [3:0] FLAGS_READ  = 4'd1;
    localparam logic [3:0] FLAGS_WRITE = 4'd2;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CLEAR  = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_RESCAN = 10'b0000001000,
        S_FIX    = 10'b0000010000,
        S_FIND   = 10'b0000100000,
        S_DECIDE = 10'b0001000000,
        S_VREAD  = 10'b0010000000,
        S_WRITE  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

endpackage

### hdl/lrsc_store.sv
// Slot store: one synchronous memory holding key, flags, mapped bit and stamp.
module lrsc_store #(
    parameter int SLOTS      = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic                     clk,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output logic [31:0]              rd_handle,
    output logic [31:0]              rd_target,
    output logic [3:0]               rd_flags,
    output logic                     rd_mapped,
    output logic [STAMP_BITS-1:0]    rd_stamp,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  logic [31:0]              wr_handle,
    input  logic [31:0]              wr_target,
    input  logic [3:0]               wr_flags,
    input  logic                     wr_mapped,
    input  logic [STAMP_BITS-1:0]    wr_stamp
);

    localparam int W = 32 + 32 + 4 + 1 + STAMP_BITS;

    logic [W-1:0] mem [SLOTS];
    logic [W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wr_handle, wr_target, wr_flags, wr_mapped, wr_stamp};
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign {rd_handle, rd_target, rd_flags, rd_mapped, rd_stamp} = rdata_reg;

endmodule

### hdl/lru_resource_slot_cache.sv
// Channel | Ports                                                  | Handshake
// cmd     | cmd handle target direction keep_mapped flags_*        | start & !busy
// result  | status slot_index victim_* map_performed mapped_after  | done strobe
//         | flags_used is_pixel_buffer                             |
// config  | cfg_data                                               | cfg_valid & cfg_ready
//
// After reset a clearing pass writes every slot with busy high.
// While busy: a flush clears every slot; undefined commands do no work; the
// others scan the capacity for the key over the single read port, then an
// insert searches for a free or oldest slot, and a clock wrap first rescans
// the live stamps and rebases them (the rebase is skipped when none is live).
// Each result is on the ports for one cycle with done high, in the first cycle
// with busy low; it cannot be held.
module lru_resource_slot_cache #(
    parameter int SLOTS      = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [31:0] handle,
    input  logic [31:0] target,
    input  logic        direction,
    input  logic        keep_mapped,
    input  logic        flags_given,
    input  logic [3:0]  flags_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [9:0]  slot_index,
    output logic [31:0] victim_handle,
    output logic [31:0] victim_target,
    output logic        victim_was_mapped,
    output logic        map_performed,
    output logic        mapped_after,
    output logic [3:0]  flags_used,
    output logic        is_pixel_buffer
);

    localparam int AW = $clog2(SLOTS);
    localparam int SB = STAMP_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [SB-1:0] ONES = {SB{1'b1}};

    lrsc_pkg::state_t state_reg, state_next;

    logic [9:0]    cap_reg;
    logic [SB-1:0] clock_reg, clock_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          vld_reg, vld_next;   // read data valid for slot idx_reg-1
    logic [AW-1:0] ridx_reg, ridx_next; // slot whose data arrives
    logic [AW-1:0] hit_reg, hit_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [SB-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic          any_reg, any_next;
    logic [AW-1:0] old_reg, old_next;
    logic [SB-1:0] olds_reg, olds_next;
    logic [AW-1:0] free_reg, free_next;
    logic          done_pend_reg;

    // Latched command word.
    logic [2:0]  c_cmd_reg;
    logic [31:0] c_h_reg, c_t_reg;
    logic [3:0]  c_fl_reg;
    logic        c_km_reg;

    // Result registers.
    logic        done_reg, done_next;
    logic [2:0]  st_reg, st_next;
    logic [9:0]  si_reg, si_next;
    logic [31:0] vh_reg, vh_next, vt_reg, vt_next;
    logic        vm_reg, vm_next, mp_reg, mp_next, ma_reg, ma_next;
    logic [3:0]  fu_reg, fu_next;
    logic        pb_reg, pb_next;

    // Memory ports.
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [31:0]   rd_h, rd_t, wr_h, wr_t;
    logic [3:0]    rd_f, wr_f;
    logic          rd_m, wr_m;
    logic [SB-1:0] rd_s, wr_s;

    lrsc_store #(.SLOTS(SLOTS), .STAMP_BITS(SB)) u_store (
        .clk(clk), .raddr(raddr),
        .rd_handle(rd_h), .rd_target(rd_t), .rd_flags(rd_f),
        .rd_mapped(rd_m), .rd_stamp(rd_s),
        .we(we), .waddr(waddr),
        .wr_handle(wr_h), .wr_target(wr_t), .wr_flags(wr_f),
        .wr_mapped(wr_m), .wr_stamp(wr_s)
    );

    // Effective capacity as a slot index.
    logic [AW-1:0] ecap;
    always_comb
    begin
        if (cap_reg == 10'd0)
            ecap = AW'(1);
        else if ({22'd0, cap_reg} > SLOTS - 1)
            ecap = LAST_SLOT;
        else
            ecap = AW'(cap_reg);
    end

    logic accept;
    assign accept    = start && !busy;
    assign busy      = (state_reg != lrsc_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    logic live, keym;
    assign live = (rd_s != '0);
    assign keym = live && (rd_h == c_h_reg) && (rd_t == c_t_reg);

    logic [SB-1:0] off, nc;
    assign off = lo_reg - SB'(1);
    assign nc  = hi_reg - off + SB'(1);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lrsc_pkg::CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    // Command latch.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c_cmd_reg <= cmd;
            c_h_reg   <= handle;
            c_t_reg   <= target;
            c_km_reg  <= keep_mapped;
            c_fl_reg  <= flags_given ? flags_value
                       : (direction ? lrsc_pkg::FLAGS_WRITE : lrsc_pkg::FLAGS_READ);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        clock_next = clock_reg;
        idx_next = idx_reg; vld_next = 1'b0; ridx_next = idx_reg;
        hit_next = hit_reg; slot_next = slot_reg;
        lo_next = lo_reg; hi_next = hi_reg; any_next = any_reg;
        old_next = old_reg; olds_next = olds_reg; free_next = free_reg;
        done_next = 1'b0;
        st_next = st_reg; si_next = si_reg; vh_next = vh_reg; vt_next = vt_reg;
        vm_next = vm_reg; mp_next = mp_reg; ma_next = ma_reg; fu_next = fu_reg;
        pb_next = pb_reg;
        raddr = idx_reg;
        we = 1'b0; waddr = idx_reg;
        wr_h = '0; wr_t = '0; wr_f = '0; wr_m = 1'b0; wr_s = '0;

        case (state_reg)
            lrsc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    st_next = lrsc_pkg::ST_NONE; si_next = '0; vh_next = '0;
                    vt_next = '0; vm_next = 1'b0; mp_next = 1'b0; ma_next = 1'b0;
                    fu_next = '0;
                    pb_next = (target == lrsc_pkg::PBO_TARGET_A)
                           || (target == lrsc_pkg::PBO_TARGET_B);
                    idx_next = AW'(1);
                    hit_next = '0;
                    if (cmd == lrsc_pkg::CMD_FLUSH)
                    begin
                        idx_next = '0;
                        clock_next = '0;
                        state_next = lrsc_pkg::S_CLEAR;
                    end
                    else if (cmd > lrsc_pkg::CMD_ACCESS_KM)
                    begin
                        state_next = lrsc_pkg::S_DONE;
                    end
                    else
                    begin
                        clock_next = clock_reg + SB'(1);
                        lo_next = ONES; hi_next = '0; any_next = 1'b0;
                        state_next = (clock_next == '0) ? lrsc_pkg::S_RESCAN
                                                        : lrsc_pkg::S_SCAN;
                    end
                end
            end

            // Write zero into every slot.
            lrsc_pkg::S_CLEAR:
            begin
                we = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_SLOT)
                    state_next = lrsc_pkg::S_DONE;
            end

            // Clock wrap: find oldest and newest live stamps.
            lrsc_pkg::S_RESCAN:
            begin
                if (vld_reg && live)
                begin
                    any_next = 1'b1;
                    if (rd_s < lo_reg) lo_next = rd_s;
                    if (rd_s > hi_reg) hi_next = rd_s;
                end
                if (vld_reg && ridx_reg == ecap)
                begin
                    idx_next = AW'(1);
                    if (!any_next)
                    begin
                        clock_next = SB'(1);
                        state_next = lrsc_pkg::S_SCAN;
                    end
                    else
                        state_next = lrsc_pkg::S_FIX;
                end
                else if (idx_reg <= ecap)
                begin
                    vld_next = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Clock wrap: rebase every live stamp.
            lrsc_pkg::S_FIX:
            begin
                if (vld_reg && live)
                begin
                    we = 1'b1; waddr = ridx_reg;
                    wr_h = rd_h; wr_t = rd_t; wr_f = rd_f; wr_m = rd_m;
                    wr_s = rd_s - off;
                end
                if (vld_reg && ridx_reg == ecap)
                begin
                    clock_next = (nc == '0) ? ONES : nc;
                    idx_next = AW'(1);
                    state_next = lrsc_pkg::S_SCAN;
                end
                else if (idx_reg <= ecap)
                begin
                    vld_next = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Lookup by key; first match wins.
            lrsc_pkg::S_SCAN:
            begin
                if (vld_reg && keym && hit_reg == '0)
                    hit_next = ridx_reg;
                if (vld_reg && ridx_reg == ecap)
                begin
                    idx_next = AW'(1);
                    free_next = '0;
                    old_next = AW'(1);
                    olds_next = ONES;
                    if (hit_next != '0)
                    begin
                        raddr = hit_next;
                        idx_next = hit_next;
                        state_next = lrsc_pkg::S_DECIDE;
                    end
                    else if (c_cmd_reg == lrsc_pkg::CMD_UNMAP
                             || c_cmd_reg == lrsc_pkg::CMD_UNREGISTER)
                        state_next = lrsc_pkg::S_DONE;
                    else
                        state_next = lrsc_pkg::S_FIND;
                end
                else if (idx_reg <= ecap)
                begin
                    vld_next = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Miss: first free slot, else oldest stamp, lowest index on ties.
            lrsc_pkg::S_FIND:
            begin
                if (vld_reg)
                begin
                    if (!live && free_reg == '0) free_next = ridx_reg;
                    if (rd_s < olds_reg)
                    begin
                        olds_next = rd_s; old_next = ridx_reg;
                    end
                end
                if (vld_reg && ridx_reg == ecap)
                begin
                    slot_next = (free_next != '0) ? free_next : old_next;
                    raddr = slot_next;
                    idx_next = slot_next;
                    state_next = lrsc_pkg::S_VREAD;
                end
                else if (idx_reg <= ecap)
                begin
                    vld_next = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Keep reading the chosen slot and clear the hit index.
            lrsc_pkg::S_VREAD:
            begin
                raddr = slot_reg;
                hit_next = '0;
                state_next = lrsc_pkg::S_DECIDE;
            end

            // Slot data for hit_reg (or slot_reg on a miss) is on rd_*.
            lrsc_pkg::S_DECIDE:
            begin
                state_next = lrsc_pkg::S_WRITE;
                if (hit_reg != '0)
                    slot_next = hit_reg;
            end

            // Modify and write back.
            lrsc_pkg::S_WRITE:
            begin
                we = 1'b1; waddr = slot_reg;
                si_next = 10'(slot_reg);
                if (c_cmd_reg == lrsc_pkg::CMD_UNMAP
                    || c_cmd_reg == lrsc_pkg::CMD_UNREGISTER)
                begin
                    st_next = lrsc_pkg::ST_HIT;
                    vm_next = rd_m;
                    if (c_cmd_reg == lrsc_pkg::CMD_UNMAP)
                    begin
                        wr_h = rd_h; wr_t = rd_t; wr_f = rd_f; wr_s = clock_reg;
                    end
                end
                else
                begin
                    fu_next = c_fl_reg;
                    wr_h = c_h_reg; wr_t = c_t_reg; wr_f = c_fl_reg;
                    wr_s = clock_reg;
                    if (hit_reg != '0 && rd_f == c_fl_reg)
                    begin
                        st_next = lrsc_pkg::ST_HIT;
                        mp_next = !rd_m;
                    end
                    else
                    begin
                        mp_next = 1'b1;
                        if (hit_reg != '0)
                        begin
                            st_next = lrsc_pkg::ST_REREG;
                            vm_next = rd_m;
                        end
                        else if (rd_s == '0)
                            st_next = lrsc_pkg::ST_FILLED;
                        else
                        begin
                            st_next = lrsc_pkg::ST_EVICTED;
                            vh_next = rd_h; vt_next = rd_t; vm_next = rd_m;
                        end
                    end
                    wr_m = !(c_cmd_reg == lrsc_pkg::CMD_ACCESS_TR && !c_km_reg);
                    ma_next = wr_m;
                end
                state_next = lrsc_pkg::S_DONE;
            end

            lrsc_pkg::S_DONE:
            begin
                done_next = 1'b1;
                state_next = lrsc_pkg::S_IDLE;
            end

            default:
            begin
                state_next = lrsc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrsc_pkg::S_CLEAR;
            clock_reg <= '0;
            idx_reg   <= '0;
            vld_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= (state_reg == lrsc_pkg::S_CLEAR && idx_reg == LAST_SLOT
                          && !done_pend_reg) ? lrsc_pkg::S_IDLE : state_next;
            clock_reg <= clock_next;
            idx_reg   <= idx_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
        end
    end

    // A flush reports a result; the clearing pass after reset does not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_pend_reg <= 1'b0;
        else if (accept)
            done_pend_reg <= 1'b1;
        else if (done_next)
            done_pend_reg <= 1'b0;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next; hit_reg <= hit_next; slot_reg <= slot_next;
        lo_reg <= lo_next; hi_reg <= hi_next; any_reg <= any_next;
        old_reg <= old_next; olds_reg <= olds_next; free_reg <= free_next;
        st_reg <= st_next; si_reg <= si_next; vh_reg <= vh_next; vt_reg <= vt_next;
        vm_reg <= vm_next; mp_reg <= mp_next; ma_reg <= ma_next; fu_reg <= fu_next;
        pb_reg <= pb_next;
    end

    assign done              = done_reg;
    assign status            = st_reg;
    assign slot_index        = si_reg;
    assign victim_handle     = vh_reg;
    assign victim_target     = vt_reg;
    assign victim_was_mapped = vm_reg;
    assign map_performed     = mp_reg;
    assign mapped_after      = ma_reg;
    assign flags_used        = fu_reg;
    assign is_pixel_buffer   = pb_reg;

    // A result strobe comes only at the end of a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    // An accepted command sets busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy) else $error("accepted command not busy");
    // Slot index stays within the slot table.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({22'd0, slot_index} <= SLOTS - 1)) else $error("slot range");
    // An eviction always reports a nonzero slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == lrsc_pkg::ST_EVICTED) |-> slot_index != 10'd0)
        else $error("evict slot zero");

endmodule

### test/lru_resource_slot_cache_checker.sv
module lru_resource_slot_cache_checker #(
    parameter int SLOTS      = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  cmd,
    input  logic [31:0] handle,
    input  logic [31:0] target,
    input  logic        direction,
    input  logic        keep_mapped,
    input  logic        flags_given,
    input  logic [3:0]  flags_value,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [9:0]  slot_index,
    input  logic [31:0] victim_handle,
    input  logic [31:0] victim_target,
    input  logic        victim_was_mapped,
    input  logic        map_performed,
    input  logic        mapped_after,
    input  logic [3:0]  flags_used,
    input  logic        is_pixel_buffer,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot;
        logic [31:0] vhandle;
        logic [31:0] vtarget;
        logic        vmapped;
        logic        mapped_now;
        logic        mapped_post;
        logic [3:0]  flags;
        logic        pbo;
    } outcome_t;

    // Shadow copy of the slot table, the tick clock and the capacity register.
    logic [31:0]           sh_handle [SLOTS];
    logic [31:0]           sh_target [SLOTS];
    logic [3:0]            sh_flags  [SLOTS];
    logic                  sh_mapped [SLOTS];
    logic [STAMP_BITS-1:0] sh_stamp  [SLOTS];
    logic [STAMP_BITS-1:0] tick;
    logic [9:0]            capacity;

    outcome_t outcomes_due[$];

    function automatic int usable_slots();
        int c;
        c = int'(capacity);
        if (c < 1) c = 1;
        if (c > SLOTS - 1) c = SLOTS - 1;
        return c;
    endfunction

    task automatic free_slot(input int i);
        sh_handle[i] = '0;
        sh_target[i] = '0;
        sh_flags[i]  = '0;
        sh_mapped[i] = 1'b0;
        sh_stamp[i]  = '0;
    endtask

    task automatic clear_table();
        for (int i = 0; i < SLOTS; i++) free_slot(i);
        tick = '0;
    endtask

    // Advance the tick; on wrap, compress live stamps to keep the LRU order.
    task automatic advance_tick(input int c);
        logic [STAMP_BITS-1:0] lo, hi, off, nc;
        bit any;
        tick = tick + 1'b1;
        if (tick != '0) return;
        lo = '1;
        hi = '0;
        any = 0;
        for (int i = 1; i <= c; i++)
        begin
            if (sh_stamp[i] != '0)
            begin
                any = 1;
                if (sh_stamp[i] < lo) lo = sh_stamp[i];
                if (sh_stamp[i] > hi) hi = sh_stamp[i];
            end
        end
        if (!any)
        begin
            tick = STAMP_BITS'(1);
            return;
        end
        off = lo - 1'b1;
        for (int i = 1; i <= c; i++)
            if (sh_stamp[i] != '0) sh_stamp[i] = sh_stamp[i] - off;
        nc = hi - off + 1'b1;
        tick = (nc == '0) ? '1 : nc;
    endtask

    // Work out the result of one command word and update the shadow table.
    task automatic cache_command(input logic [2:0] c_cmd, input logic [31:0] h,
                                 input logic [31:0] t, input logic dir,
                                 input logic km, input logic fg,
                                 input logic [3:0] fv, output outcome_t o);
        int c, hit, slot;
        logic [3:0] fl;
        o = '0;
        o.pbo = (t == lrsc_pkg::PBO_TARGET_A) || (t == lrsc_pkg::PBO_TARGET_B);
        hit = 0;
        slot = 0;
        if (c_cmd == lrsc_pkg::CMD_FLUSH)
        begin
            clear_table();
            return;
        end
        if (c_cmd > lrsc_pkg::CMD_ACCESS_KM) return;
        c = usable_slots();
        advance_tick(c);
        for (int i = 1; i <= c; i++)
        begin
            if (hit == 0 && sh_stamp[i] != '0 && sh_handle[i] == h
                && sh_target[i] == t)
                hit = i;
        end

        // Unmap and unregister touch only an existing entry.
        if (c_cmd == lrsc_pkg::CMD_UNMAP || c_cmd == lrsc_pkg::CMD_UNREGISTER)
        begin
            if (hit == 0) return;
            sh_stamp[hit] = tick;
            o.status = lrsc_pkg::ST_HIT;
            o.slot = 10'(hit);
            o.vmapped = sh_mapped[hit];
            sh_mapped[hit] = 1'b0;
            if (c_cmd == lrsc_pkg::CMD_UNREGISTER) free_slot(hit);
            return;
        end

        fl = fg ? fv : (dir ? lrsc_pkg::FLAGS_WRITE : lrsc_pkg::FLAGS_READ);
        o.flags = fl;
        if (hit != 0 && sh_flags[hit] == fl)
        begin
            sh_stamp[hit] = tick;
            slot = hit;
            o.status = lrsc_pkg::ST_HIT;
        end
        else
        begin
            if (hit != 0)
            begin
                slot = hit;
                o.status = lrsc_pkg::ST_REREG;
                o.vmapped = sh_mapped[hit];
            end
            else
            begin
                for (int i = 1; i <= c; i++)
                    if (slot == 0 && sh_stamp[i] == '0) slot = i;
                if (slot != 0)
                begin
                    o.status = lrsc_pkg::ST_FILLED;
                end
                else
                begin
                    // Oldest stamp wins, lowest index on ties.
                    slot = 1;
                    for (int i = 2; i <= c; i++)
                        if (sh_stamp[i] < sh_stamp[slot]) slot = i;
                    o.status = lrsc_pkg::ST_EVICTED;
                    o.vhandle = sh_handle[slot];
                    o.vtarget = sh_target[slot];
                    o.vmapped = sh_mapped[slot];
                end
            end
            free_slot(slot);
            sh_handle[slot] = h;
            sh_target[slot] = t;
            sh_flags[slot] = fl;
            sh_stamp[slot] = tick;
        end
        o.slot = 10'(slot);
        if (!sh_mapped[slot])
        begin
            sh_mapped[slot] = 1'b1;
            o.mapped_now = 1'b1;
        end
        if (c_cmd == lrsc_pkg::CMD_ACCESS_TR && !km) sh_mapped[slot] = 1'b0;
        o.mapped_post = sh_mapped[slot];
    endtask

    // Watch the three channels; results are compared against the oldest outcome.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o, got;
        if (!rst_n)
        begin
            clear_table();
            capacity = lrsc_pkg::CAP_RESET;
            outcomes_due.delete();
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{status, slot_index, victim_handle, victim_target,
                        victim_was_mapped, map_performed, mapped_after,
                        flags_used, is_pixel_buffer};
                if (outcomes_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word status=%0d slot=%0d",
                                 $realtime, status, slot_index);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    o = outcomes_due.pop_front();
                    if (o !== got)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: result mismatch\n",
                                      "  exp st=%0d slot=%0d vh=%h vt=%h vm=%b",
                                      " mp=%b ma=%b fl=%0d pb=%b\n",
                                      "  got st=%0d slot=%0d vh=%h vt=%h vm=%b",
                                      " mp=%b ma=%b fl=%0d pb=%b"},
                                     $realtime,
                                     o.status, o.slot, o.vhandle, o.vtarget, o.vmapped,
                                     o.mapped_now, o.mapped_post, o.flags, o.pbo,
                                     got.status, got.slot, got.vhandle, got.vtarget,
                                     got.vmapped, got.mapped_now, got.mapped_post,
                                     got.flags, got.pbo);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) capacity = cfg_data;
            if (start && !busy)
            begin
                cache_command(cmd, handle, target, direction, keep_mapped,
                              flags_given, flags_value, o);
                outcomes_due.push_back(o);
            end
            pending <= outcomes_due.size();
        end
    end

endmodule

### test/tb_lru_resource_slot_cache.sv
module tb_lru_resource_slot_cache;
    timeunit 1ns;
    timeprecision 1ps;

    // A short stamp width makes the clock wrap every few dozen commands.
    localparam int SLOTS      = 1024;
    localparam int STAMP_BITS = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  cmd = lrsc_pkg::CMD_FLUSH;
    logic [31:0] handle = '0;
    logic [31:0] target = '0;
    logic        direction = 1'b0;
    logic        keep_mapped = 1'b0;
    logic        flags_given = 1'b0;
    logic [3:0]  flags_value = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;
    logic        done;
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [31:0] victim_handle;
    logic [31:0] victim_target;
    logic        victim_was_mapped;
    logic        map_performed;
    logic        mapped_after;
    logic [3:0]  flags_used;
    logic        is_pixel_buffer;
    int          mismatches;
    int          pending;

    int          idle_pct;
    logic [31:0] key_handles [16];
    logic [31:0] key_targets [16];

    always #5 clk = ~clk;

    lru_resource_slot_cache #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) u_top (.*);

    lru_resource_slot_cache_checker #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) u_checker (.*);

    // Hold start high until the block takes the command word.
    task automatic send(input logic [2:0] c, input logic [31:0] h, input logic [31:0] t,
                        input logic dir, input logic km, input logic fg,
                        input logic [3:0] fv);
        start <= 1'b1;
        cmd <= c;
        handle <= h;
        target <= t;
        direction <= dir;
        keep_mapped <= km;
        flags_given <= fg;
        flags_value <= fv;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result word.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [9:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly keys from a small pool so that hits and re-registrations happen.
    task automatic send_random();
        int k, r;
        logic [2:0] c;
        logic [31:0] h, t;
        r = $urandom_range(99);
        if (r < 2) c = lrsc_pkg::CMD_FLUSH;
        else if (r < 14) c = lrsc_pkg::CMD_UNMAP;
        else if (r < 24) c = lrsc_pkg::CMD_UNREGISTER;
        else if (r < 59) c = lrsc_pkg::CMD_ACCESS_TR;
        else if (r < 94) c = lrsc_pkg::CMD_ACCESS_KM;
        else c = 3'($urandom_range(5, 7));
        k = $urandom_range(15);
        h = key_handles[k];
        t = key_targets[k];
        if ($urandom_range(99) < 15)
        begin
            h = $urandom;
            t = $urandom;
        end
        send(c, h, t, 1'($urandom), 1'($urandom), $urandom_range(99) < 30,
             ($urandom_range(1) != 0) ? 4'($urandom) : 4'($urandom_range(1, 2)));
    endtask

    task automatic random_phase(input logic [9:0] cap, input int count, input int idle);
        set_capacity(cap);
        idle_pct = idle;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2 && cap == 10'd5) drain();
            send_random();
        end
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            key_handles[i] = $urandom;
            key_targets[i] = $urandom;
        end
        key_handles[0] = '0;          key_targets[0] = '0;
        key_handles[1] = '1;          key_targets[1] = '1;
        key_targets[2] = lrsc_pkg::PBO_TARGET_A;
        key_targets[3] = lrsc_pkg::PBO_TARGET_B;
        key_handles[4] = key_handles[2];
        key_targets[4] = lrsc_pkg::PBO_TARGET_B;

        idle_pct = 16;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands at the reset capacity.
        send(lrsc_pkg::CMD_ACCESS_TR, '0, '0, 1'b0, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_ACCESS_KM, '1, '1, 1'b1, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_ACCESS_TR, 32'h1234, lrsc_pkg::PBO_TARGET_A,
             1'b0, 1'b1, 1'b1, 4'hF);
        send(lrsc_pkg::CMD_ACCESS_KM, 32'h1234, lrsc_pkg::PBO_TARGET_B,
             1'b1, 1'b1, 1'b1, 4'h0);
        send(lrsc_pkg::CMD_ACCESS_TR, '0, '0, 1'b0, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_ACCESS_TR, '0, '0, 1'b1, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_ACCESS_KM, '1, '1, 1'b0, 1'b0, 1'b1, 4'd2);
        send(lrsc_pkg::CMD_UNMAP, '1, '1, 1'b0, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_UNMAP, 32'h5555, 32'hAAAA, 1'b0, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_UNREGISTER, 32'h1234, lrsc_pkg::PBO_TARGET_A,
             1'b0, 1'b0, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_UNREGISTER, 32'h1234, lrsc_pkg::PBO_TARGET_A,
             1'b0, 1'b0, 1'b0, 4'd0);
        send(3'd5, '1, lrsc_pkg::PBO_TARGET_A, 1'b1, 1'b1, 1'b1, 4'hF);
        send(3'd6, '0, '0, 1'b0, 1'b0, 1'b0, 4'd0);
        send(3'd7, '1, '1, 1'b1, 1'b1, 1'b1, 4'hF);
        for (int i = 0; i < 9; i++)
            send(lrsc_pkg::CMD_ACCESS_TR, 32'h100 + i, 32'h7, 1'b0, 1'b1, 1'b0, 4'd0);
        send(lrsc_pkg::CMD_FLUSH, '0, lrsc_pkg::PBO_TARGET_B, 1'b0, 1'b0, 1'b0, 4'd0);

        // Random phases over several capacities, set without a flush; the capacity 5 phase drains halfway.
        random_phase(10'd1, 60, 16);
        random_phase(10'd1023, 15, 16);
        random_phase(10'd0, 50, 16);
        random_phase(10'd5, 70, 48);
        random_phase(10'd3, 60, 48);
        random_phase(10'd16, 70, 48);
        random_phase(10'd64, 60, 0);
        random_phase(10'd8, 65, 0);

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/lrsc_pkg.sv
hdl/lrsc_store.sv
hdl/lru_resource_slot_cache.sv
test/lru_resource_slot_cache_checker.sv
test/tb_lru_resource_slot_cache.sv
